[hw/rtl/mbsrc_pkg.sv]
package mbsrc_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic has_majority;
		logic overflow;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // item accepted
		logic scan;    // count pass running
		logic finish;  // capture verdict
		logic clear;   // result taken, start new set
	} mbsrc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} mbsrc_sts_t;

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

endpackage

[hw/rtl/mbsrc_ctrl.sv]
module mbsrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_last,
	input  logic                result_stall,
	input  mbsrc_pkg::mbsrc_sts_t sts,
	output mbsrc_pkg::mbsrc_cmd_t cmd,
	output logic                item_stall,
	output logic                result_valid
);
	import mbsrc_pkg::*;

	logic [1:0] state_q;
	logic       accept;

	assign item_stall   = (state_q != S_LOAD);
	assign result_valid = (state_q == S_OUT);
	assign accept       = item_valid && (state_q == S_LOAD);

	always_comb begin
		cmd.load   = accept;
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_SCAN) && sts.scan_done;
		cmd.clear  = (state_q == S_OUT) && !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: if (accept && item_last) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= S_OUT;
				S_OUT:  if (!result_stall) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_out_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_SCAN)
		else $error("result shown without count pass");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> item_stall && !result_valid)
		else $error("item taken during count pass");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result dropped");

endmodule

[hw/rtl/mbsrc_dp.sv]
module mbsrc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbsrc_pkg::item_t      item,
	input  mbsrc_pkg::mbsrc_cmd_t cmd,
	output mbsrc_pkg::mbsrc_sts_t sts,
	output mbsrc_pkg::result_t    result
);
	import mbsrc_pkg::*;

	logic [31:0]      mem [MAX_ITEMS];
	logic [CNT_W-1:0] count_q, vote_q, match_q, rd_idx_q;
	logic [31:0]      cand_q, rd_data_s1;
	logic             rd_pend_s1, ovf_q, has_q, store, rd_issue;

	assign store    = cmd.load && (count_q < CNT_W'(MAX_ITEMS));
	assign rd_issue = cmd.scan && (rd_idx_q < count_q);
	assign sts.scan_done = cmd.scan && !rd_issue && !rd_pend_s1;
	assign result.has_majority = has_q;
	assign result.overflow     = ovf_q;

	// element store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store) mem[count_q[ADDR_W-1:0]] <= item.value;
		if (rd_issue) rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			vote_q     <= '0;
			match_q    <= '0;
			rd_idx_q   <= '0;
			cand_q     <= '0;
			rd_pend_s1 <= 1'b0;
			ovf_q      <= 1'b0;
			has_q      <= 1'b0;
		end else if (cmd.clear) begin
			count_q    <= '0;
			vote_q     <= '0;
			match_q    <= '0;
			rd_idx_q   <= '0;
			rd_pend_s1 <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (cmd.load && !store) ovf_q <= 1'b1;
			// pairwise cancel vote picks the only possible majority
			if (store) begin
				count_q <= count_q + 1'b1;
				if (vote_q == '0) begin
					cand_q <= item.value;
					vote_q <= CNT_W'(1);
				end else if (cand_q == item.value) begin
					vote_q <= vote_q + 1'b1;
				end else begin
					vote_q <= vote_q - 1'b1;
				end
			end
			rd_pend_s1 <= rd_issue;
			if (rd_issue) rd_idx_q <= rd_idx_q + 1'b1;
			if (rd_pend_s1 && rd_data_s1 == cand_q) match_q <= match_q + 1'b1;
			if (cmd.finish) has_q <= (match_q > (count_q >> 1));
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count past capacity");
	a_match_cap: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= rd_idx_q)
		else $error("more matches than reads");
	a_finish_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> rd_idx_q == count_q)
		else $error("verdict before all elements read");

endmodule

[hw/rtl/majority_by_sort_and_run_count_core.sv]
// majority detector: words arrive one per cycle (stall low while loading) and are
// stored in a 1024-entry memory; a candidate is tracked by a running vote as they
// load. the word marked last starts one count pass over the memory (one read per
// cycle through the single read port), then one result word shows has_majority
// (some value occurs more than floor(n/2) times) and overflow (words past 1024
// were dropped). no new words are taken until the result word is accepted.
module majority_by_sort_and_run_count_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  mbsrc_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output mbsrc_pkg::result_t result
);
	import mbsrc_pkg::*;

	mbsrc_cmd_t cmd;
	mbsrc_sts_t sts;

	// sequencing: load, count pass, hold result
	mbsrc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd),
		.item_stall   (item_stall),
		.result_valid (result_valid)
	);

	// store, vote and match counter
	mbsrc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

[test/majority_by_sort_and_run_count_core_tb.sv]
`timescale 1ns / 100ps

module majority_by_sort_and_run_count_core_tb;
	import mbsrc_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	majority_by_sort_and_run_count_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// one directed row: a word, and optionally the verdict typed in by hand
	typedef struct {
		logic signed [31:0] value;
		logic               last;
		logic               typed;
		result_t            verdict;
	} row_t;

	// words of the open set as the predictor sees them, capped at MAX_ITEMS
	logic signed [31:0] set_words[$];
	logic               set_dropped;
	result_t            verdicts_due[$];
	int                 failures;
	logic               sending_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// majority over the stored words: count each value with an associative tally
	function automatic logic majority_of(input logic signed [31:0] words[$]);
		int tally[logic signed [31:0]];
		int n;
		n = words.size();
		foreach (words[i]) begin
			if (tally.exists(words[i])) tally[words[i]]++;
			else tally[words[i]] = 1;
			if (tally[words[i]] > n / 2) return 1'b1;
		end
		return n <= 1;
	endfunction

	// predictor: feed one accepted word, yields a verdict on the last word
	task automatic take_word(input item_t w, input logic typed, input result_t typed_verdict);
		result_t r;
		if (set_words.size() < MAX_ITEMS) set_words = {set_words, w.value};
		else set_dropped = 1'b1;
		if (w.last) begin
			r.has_majority = majority_of(set_words);
			r.overflow     = set_dropped;
			if (typed && r != typed_verdict) begin
				$error("has_majority/overflow expected %b predicted %b",
					typed_verdict, r);
				failures++;
			end
			verdicts_due = {verdicts_due, r};
			set_words.delete();
			set_dropped = 1'b0;
		end
	endtask

	// offer one word after a random gap, wait for acceptance
	task automatic send_word(input item_t w, input logic typed, input result_t tv);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		take_word(w, typed, tv);
	endtask

	task automatic send_set(input int n, input int kind);
		item_t w;
		logic signed [31:0] maj;
		maj = $urandom;
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: w.value = $urandom;                              // spread out
				1: w.value = ($urandom_range(0, 2) != 0) ? maj : $urandom; // likely majority
				2: w.value = $urandom_range(0, 3) - 2;             // tiny alphabet
				default: w.value = (i % 2) ? maj : ~maj;           // two values alternating
			endcase
			w.last = (i == n - 1);
			send_word(w, 1'b0, '0);
		end
	endtask

	row_t rows[15];

	initial begin
		item_t w;
		int n;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		failures     = 0;
		sending_done = 1'b0;
		set_dropped  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			// single words: always a majority, both sign extremes
			'{32'sh7fffffff, 1'b1, 1'b1, 2'b10},
			'{32'sh80000000, 1'b1, 1'b1, 2'b10},
			'{32'sh0,        1'b1, 1'b1, 2'b10},
			// two different: no majority
			'{32'sh80000000, 1'b0, 1'b0, 2'b00},
			'{32'sh7fffffff, 1'b1, 1'b1, 2'b00},
			// all equal
			'{-32'sd1, 1'b0, 1'b0, 2'b00},
			'{-32'sd1, 1'b0, 1'b0, 2'b00},
			'{-32'sd1, 1'b1, 1'b1, 2'b10},
			// 2 of 3 with signed neighbors
			'{-32'sd1, 1'b0, 1'b0, 2'b00},
			'{32'sd1,  1'b0, 1'b0, 2'b00},
			'{32'sd1,  1'b1, 1'b1, 2'b10},
			// 2 of 4 is not more than half
			'{32'sd5, 1'b0, 1'b0, 2'b00},
			'{32'sd5, 1'b0, 1'b0, 2'b00},
			'{32'sd6, 1'b0, 1'b0, 2'b00},
			'{32'sd7, 1'b1, 1'b1, 2'b00}
		};
		foreach (rows[i]) begin
			w.value = rows[i].value;
			w.last  = rows[i].last;
			send_word(w, rows[i].typed, rows[i].verdict);
		end

		// overflow: MAX_ITEMS + 3 equal words, extras dropped, last among them
		for (int i = 0; i < MAX_ITEMS + 3; i++) begin
			w.value = 32'sh55aa55aa;
			w.last  = (i == MAX_ITEMS + 2);
			send_word(w, w.last, 2'b11);
		end

		item_valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);

		// random sets, mostly small
		n = 0;
		while (n < 460) begin
			int sz;
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 9);
			send_set(sz, $urandom_range(0, 3));
			n += sz;
		end
		item_valid   <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off early on while words keep coming
	initial begin
		int gap;
		result_stall = 1'b1;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// checker: compare each accepted result word against the oldest verdict
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (verdicts_due.size() == 0) begin
				$error("result word with nothing expected: %b", result);
				failures++;
			end else begin
				result_t e;
				e = verdicts_due.pop_front();
				if (e.has_majority !== result.has_majority) begin
					$error("has_majority expected %b actual %b", e.has_majority,
						result.has_majority);
					failures++;
				end
				if (e.overflow !== result.overflow) begin
					$error("overflow expected %b actual %b", e.overflow, result.overflow);
					failures++;
				end
			end
		end
	end

	// end of run: drain, then a short settle for stray words
	initial begin
		wait (sending_done === 1'b1);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (2 * MAX_ITEMS + 20) @(posedge clk);
		if (failures == 0 && verdicts_due.size() == 0)
			$display("[majority_by_sort_and_run_count_core] OK");
		else
			$display("[majority_by_sort_and_run_count_core] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[majority_by_sort_and_run_count_core] ERROR");
		$finish;
	end

endmodule

[majority_by_sort_and_run_count_core.f]
hw/rtl/mbsrc_pkg.sv
hw/rtl/mbsrc_ctrl.sv
hw/rtl/mbsrc_dp.sv
hw/rtl/majority_by_sort_and_run_count_core.sv
test/majority_by_sort_and_run_count_core_tb.sv
